[rtl/lep_pkg.sv]
`default_nettype none

package lep_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int VALUE_WIDTH = 24;
    localparam int COEF_W      = 24;
    localparam int DT_W        = 16;
    localparam int SCALE_W     = 23;
    localparam int CNT_W       = 17;
    localparam int COL_W       = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int OPW    = VALUE_WIDTH + 1;
    localparam int MAG_W  = VALUE_WIDTH;
    localparam int PROD_W = 2 * MAG_W;
    localparam int RM_W   = PROD_W + 1 - FRAC_BITS;
    localparam int PC_W   = 5;

    localparam logic signed [VALUE_WIDTH-1:0] INIT_X =
        VALUE_WIDTH'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

    localparam logic [COEF_W-1:0]  CFG_A_RST  = COEF_W'(64'd5 << FRAC_BITS);
    localparam logic [COEF_W-1:0]  CFG_B_RST  = COEF_W'(64'd15 << FRAC_BITS);
    localparam logic [COEF_W-1:0]  CFG_C_RST  = COEF_W'(64'd1 << FRAC_BITS);
    localparam logic [DT_W-1:0]    CFG_DT_RST =
        DT_W'(((64'd2 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [SCALE_W-1:0] CFG_SC_RST =
        SCALE_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic [CNT_W-1:0]   CFG_N_RST  = CNT_W'(6000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_A,
        CFG_COEF_B,
        CFG_COEF_C,
        CFG_TIME_STEP,
        CFG_OUT_SCALE,
        CFG_POINT_COUNT
    } t_cfg_idx;

    typedef struct packed {
        logic [COEF_W-1:0]  coef_a;
        logic [COEF_W-1:0]  coef_b;
        logic [COEF_W-1:0]  coef_c;
        logic [DT_W-1:0]    time_step;
        logic [SCALE_W-1:0] out_scale;
        logic [CNT_W-1:0]   point_count;
    } t_cfg;

    typedef logic [PC_W-1:0] t_pc;

    typedef enum logic [3:0] {
        SRC_X, SRC_Y, SRC_Z,
        SRC_A, SRC_B, SRC_C,
        SRC_DT, SRC_SC,
        SRC_T0, SRC_T1, SRC_T2,
        SRC_NX, SRC_NY, SRC_NZ
    } t_src;

    typedef enum logic [3:0] {
        DST_NONE,
        DST_T0, DST_T1, DST_T2,
        DST_NX, DST_NY, DST_NZ,
        DST_OX, DST_OY, DST_OZ
    } t_dst;

    typedef enum logic [1:0] {
        COL_NONE, COL_X, COL_Y, COL_Z
    } t_col;

    typedef enum logic [1:0] {
        SQ_NEXT,
        SQ_SKIP_NR,
        SQ_INIT,
        SQ_COMMIT
    } t_sop;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_seq_state;

    typedef struct packed {
        t_sop sop;
        t_pc  target;
        logic mul_go;
        t_src mul_a;
        t_src mul_b;
        t_dst mul_dst;
        logic alu_sub;
        t_src alu_a;
        t_src alu_b;
        t_dst alu_dst;
        t_col col;
    } t_uword;

    typedef struct packed {
        t_uword uw;
        logic   init;
        logic   commit;
    } t_ctrl;

    localparam t_uword UW_NOP = '{
        sop:     SQ_NEXT,
        target:  '0,
        mul_go:  1'b0,
        mul_a:   SRC_X,
        mul_b:   SRC_X,
        mul_dst: DST_NONE,
        alu_sub: 1'b0,
        alu_a:   SRC_X,
        alu_b:   SRC_X,
        alu_dst: DST_NONE,
        col:     COL_NONE
    };

    localparam t_pc PC_BODY = PC_W'(2);

    function automatic t_uword f_uw(
        input logic mul_go,
        input t_src mul_a,
        input t_src mul_b,
        input t_dst mul_dst,
        input logic alu_sub,
        input t_src alu_a,
        input t_src alu_b,
        input t_dst alu_dst,
        input t_col col
    );
        t_uword w;
        w         = UW_NOP;
        w.mul_go  = mul_go;
        w.mul_a   = mul_a;
        w.mul_b   = mul_b;
        w.mul_dst = mul_dst;
        w.alu_sub = alu_sub;
        w.alu_a   = alu_a;
        w.alu_b   = alu_b;
        w.alu_dst = alu_dst;
        w.col     = col;
        return w;
    endfunction

    // one Euler step; a product is registered in P at issue, then rounded and written back by the following word
    function automatic t_uword f_ucode(input t_pc pc);
        t_uword w;
        w = UW_NOP;
        case (pc)
            PC_W'(0): begin
                w.sop    = SQ_SKIP_NR;
                w.target = PC_BODY;
            end
            PC_W'(1): begin
                w.sop = SQ_INIT;
            end
            PC_W'(2): w = f_uw(1'b0, SRC_X, SRC_X, DST_NONE,
                               1'b1, SRC_Y, SRC_X, DST_T0, COL_X);
            PC_W'(3): w = f_uw(1'b1, SRC_A, SRC_T0, DST_NONE,
                               1'b1, SRC_B, SRC_Z, DST_T1, COL_Y);
            PC_W'(4): w = f_uw(1'b1, SRC_X, SRC_T1, DST_T0,
                               1'b0, SRC_X, SRC_X, DST_NONE, COL_Z);
            PC_W'(5): w = f_uw(1'b1, SRC_T0, SRC_DT, DST_T1,
                               1'b0, SRC_X, SRC_X, DST_NONE, COL_NONE);
            PC_W'(6): w = f_uw(1'b1, SRC_X, SRC_Y, DST_T2,
                               1'b1, SRC_T1, SRC_Y, DST_T1, COL_NONE);
            PC_W'(7): w = f_uw(1'b1, SRC_T1, SRC_DT, DST_T0,
                               1'b0, SRC_X, SRC_T2, DST_NX, COL_NONE);
            PC_W'(8): w = f_uw(1'b1, SRC_C, SRC_Z, DST_T2,
                               1'b0, SRC_X, SRC_X, DST_NONE, COL_NONE);
            PC_W'(9): w = f_uw(1'b1, SRC_NX, SRC_SC, DST_T1,
                               1'b0, SRC_Y, SRC_T2, DST_NY, COL_NONE);
            PC_W'(10): w = f_uw(1'b1, SRC_NY, SRC_SC, DST_OX,
                                1'b1, SRC_T0, SRC_T1, DST_T0, COL_NONE);
            PC_W'(11): w = f_uw(1'b1, SRC_T0, SRC_DT, DST_OY,
                                1'b0, SRC_X, SRC_X, DST_NONE, COL_NONE);
            PC_W'(12): w = f_uw(1'b0, SRC_X, SRC_X, DST_T2,
                                1'b0, SRC_X, SRC_X, DST_NONE, COL_NONE);
            PC_W'(13): w = f_uw(1'b0, SRC_X, SRC_X, DST_NONE,
                                1'b0, SRC_Z, SRC_T2, DST_NZ, COL_NONE);
            PC_W'(14): w = f_uw(1'b1, SRC_NZ, SRC_SC, DST_NONE,
                                1'b0, SRC_X, SRC_X, DST_NONE, COL_NONE);
            PC_W'(15): w = f_uw(1'b0, SRC_X, SRC_X, DST_OZ,
                                1'b0, SRC_X, SRC_X, DST_NONE, COL_NONE);
            PC_W'(16): begin
                w.sop = SQ_COMMIT;
            end
            default: w = UW_NOP;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[rtl/lep_ifs.sv]
`default_nettype none

interface lep_in_if import lep_pkg::*; ();
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface lep_out_if import lep_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] point_x;
    logic signed [VALUE_WIDTH-1:0] point_y;
    logic signed [VALUE_WIDTH-1:0] point_z;
    logic [COL_W-1:0]              color_red;
    logic [COL_W-1:0]              color_green;
    logic [COL_W-1:0]              color_blue;
    logic                          last_point;

    modport source (
        output valid, output point_x, output point_y, output point_z,
        output color_red, output color_green, output color_blue,
        output last_point, input ready
    );
    modport sink (
        input valid, input point_x, input point_y, input point_z,
        input color_red, input color_green, input color_blue,
        input last_point, output ready
    );
endinterface

`default_nettype wire

[rtl/lep_color.sv]
`default_nettype none

module lep_color import lep_pkg::*; (
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    output logic [COL_W-1:0]              o_color
);

    localparam int CN_W = (VALUE_WIDTH + 9 > FRAC_BITS + 13) ?
                          VALUE_WIDTH + 9 : FRAC_BITS + 13;
    localparam logic [63:0]     DEN      = 64'd10 << FRAC_BITS;
    localparam logic [CN_W-1:0] HALF_DEN = CN_W'(DEN / 64'd2);
    localparam logic [CN_W-1:0] CLAMP    = CN_W'(DEN * 64'd256);
    localparam int              M_W      = 12;
    localparam int              RECIP_SH = 16;
    localparam logic [12:0]     RECIP_10 = 13'd6554;

    logic [CN_W-1:0]         num;
    logic [M_W-1:0]          m;
    logic [M_W+12:0]         q;

    // round(v*255/(10<<F)); /10 done by reciprocal, exact for m < 2560
    always_comb begin
        num = (CN_W'(i_value) << 8) - CN_W'(i_value) + HALF_DEN;
        m   = num[FRAC_BITS +: M_W];
        q   = (M_W + 13)'(m) * (M_W + 13)'(RECIP_10);
        if (i_value[VALUE_WIDTH-1] || i_value == '0) begin
            o_color = '0;
        end else if (num >= CLAMP) begin
            o_color = '1;
        end else begin
            o_color = q[RECIP_SH +: COL_W];
        end
    end

endmodule

`default_nettype wire

[rtl/lep_sequencer.sv]
`default_nettype none

module lep_sequencer import lep_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    lep_in_if.sink i_in,
    input  logic   i_can_commit,
    output t_ctrl  o_ctrl
);

    t_seq_state r_state;
    t_seq_state n_state;
    t_pc        r_pc;
    logic       r_restart;
    t_uword     uw;

    assign uw = f_ucode(r_pc);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (uw.sop == SQ_COMMIT && i_can_commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready    = (r_state == ST_IDLE);
        o_ctrl.uw     = (r_state == ST_RUN) ? uw : UW_NOP;
        o_ctrl.init   = (r_state == ST_RUN) && (uw.sop == SQ_INIT);
        o_ctrl.commit = (r_state == ST_RUN) && (uw.sop == SQ_COMMIT) && i_can_commit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            priority if (r_state == ST_IDLE) begin
                r_pc <= '0;
            end else if (uw.sop == SQ_SKIP_NR && !r_restart) begin
                r_pc <= uw.target;
            end else if (uw.sop == SQ_COMMIT) begin
                if (i_can_commit) begin
                    r_pc <= '0;
                end
            end else begin
                r_pc <= r_pc + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in.valid) begin
            r_restart <= i_in.restart;
        end
    end

endmodule

`default_nettype wire

[rtl/lep_datapath.sv]
`default_nettype none

module lep_datapath import lep_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  t_ctrl      i_ctrl,
    output logic       o_can_commit,
    lep_out_if.source  o_out
);

    localparam logic [PROD_W:0]  RND_HALF = (PROD_W + 1)'(64'd1 << (FRAC_BITS - 1));
    localparam logic [RM_W-1:0]  LIM_NEG  = RM_W'(64'd1 << (VALUE_WIDTH - 1));
    localparam logic [RM_W-1:0]  LIM_POS  = RM_W'((64'd1 << (VALUE_WIDTH - 1)) - 64'd1);
    localparam logic [VALUE_WIDTH-1:0] V_MAX = {1'b0, {(VALUE_WIDTH - 1){1'b1}}};
    localparam logic [VALUE_WIDTH-1:0] V_MIN = {1'b1, {(VALUE_WIDTH - 1){1'b0}}};

    logic signed [VALUE_WIDTH-1:0] r_x, r_y, r_z;
    logic signed [VALUE_WIDTH-1:0] r_t0, r_t1, r_t2;
    logic signed [VALUE_WIDTH-1:0] r_nx, r_ny, r_nz;
    logic signed [VALUE_WIDTH-1:0] r_ox, r_oy, r_oz;
    logic [CNT_W-1:0]              r_cnt;
    logic [COL_W-1:0]              r_col_r, r_col_g, r_col_b;
    logic                          r_p_neg;
    logic [PROD_W-1:0]             r_p_mag;
    logic                          r_out_valid;
    logic signed [VALUE_WIDTH-1:0] r_out_x, r_out_y, r_out_z;
    logic [COL_W-1:0]              r_out_r, r_out_g, r_out_b;
    logic                          r_out_last;

    logic signed [OPW-1:0]         mul_a, mul_b, alu_a, alu_b;
    logic [OPW-1:0]                abs_a, abs_b;
    logic [PROD_W-1:0]             prod;
    logic [PROD_W:0]               rsum;
    logic [RM_W-1:0]               rmag, rlim;
    logic [VALUE_WIDTH-1:0]        rclip;
    logic signed [VALUE_WIDTH-1:0] mres;
    logic signed [OPW:0]           asum;
    logic                          afits;
    logic signed [VALUE_WIDTH-1:0] ares;
    logic signed [VALUE_WIDTH-1:0] col_in;
    logic [COL_W-1:0]              col_out;
    logic [CNT_W-1:0]              cnt_inc, cnt_lim;
    logic                          last;

    function automatic logic signed [OPW-1:0] f_sel(input t_src s);
        logic signed [OPW-1:0] v;
        unique case (s)
            SRC_X:   v = OPW'(r_x);
            SRC_Y:   v = OPW'(r_y);
            SRC_Z:   v = OPW'(r_z);
            SRC_A:   v = OPW'($signed(i_cfg.coef_a));
            SRC_B:   v = OPW'($signed(i_cfg.coef_b));
            SRC_C:   v = OPW'($signed(i_cfg.coef_c));
            SRC_DT:  v = OPW'(i_cfg.time_step);
            SRC_SC:  v = OPW'(i_cfg.out_scale);
            SRC_T0:  v = OPW'(r_t0);
            SRC_T1:  v = OPW'(r_t1);
            SRC_T2:  v = OPW'(r_t2);
            SRC_NX:  v = OPW'(r_nx);
            SRC_NY:  v = OPW'(r_ny);
            SRC_NZ:  v = OPW'(r_nz);
            default: v = '0;
        endcase
        return v;
    endfunction

    // sign-magnitude multiply, rounded half away from zero, saturated
    always_comb begin
        mul_a = f_sel(i_ctrl.uw.mul_a);
        mul_b = f_sel(i_ctrl.uw.mul_b);
        abs_a = mul_a[OPW-1] ? OPW'(-mul_a) : OPW'(mul_a);
        abs_b = mul_b[OPW-1] ? OPW'(-mul_b) : OPW'(mul_b);
        prod  = PROD_W'(abs_a[MAG_W-1:0]) * PROD_W'(abs_b[MAG_W-1:0]);

        rsum  = {1'b0, r_p_mag} + RND_HALF;
        rmag  = rsum[PROD_W:FRAC_BITS];
        rlim  = r_p_neg ? LIM_NEG : LIM_POS;
        rclip = (rmag > rlim) ? rlim[VALUE_WIDTH-1:0] : rmag[VALUE_WIDTH-1:0];
        mres  = $signed(r_p_neg ? (~rclip + 1'b1) : rclip);
    end

    always_comb begin
        alu_a = f_sel(i_ctrl.uw.alu_a);
        alu_b = f_sel(i_ctrl.uw.alu_b);
        asum  = i_ctrl.uw.alu_sub ? ((OPW + 1)'(alu_a) - (OPW + 1)'(alu_b))
                                  : ((OPW + 1)'(alu_a) + (OPW + 1)'(alu_b));
        afits = (&asum[OPW:VALUE_WIDTH-1]) || !(|asum[OPW:VALUE_WIDTH-1]);
        ares  = afits ? asum[VALUE_WIDTH-1:0] : (asum[OPW] ? V_MIN : V_MAX);
    end

    always_comb begin
        unique case (i_ctrl.uw.col)
            COL_X:   col_in = r_x;
            COL_Y:   col_in = r_y;
            COL_Z:   col_in = r_z;
            default: col_in = '0;
        endcase
    end

    lep_color u_color (
        .i_value (col_in),
        .o_color (col_out)
    );

    always_comb begin
        cnt_inc      = r_cnt + 1'b1;
        cnt_lim      = (i_cfg.point_count == '0) ? CNT_W'(1) : i_cfg.point_count;
        last         = (cnt_inc >= cnt_lim);
        o_can_commit = !r_out_valid || o_out.ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.uw.mul_go) begin
            r_p_neg <= mul_a[OPW-1] ^ mul_b[OPW-1];
            r_p_mag <= prod;
        end
        unique case (i_ctrl.uw.mul_dst)
            DST_T0:  r_t0 <= mres;
            DST_T1:  r_t1 <= mres;
            DST_T2:  r_t2 <= mres;
            DST_NX:  r_nx <= mres;
            DST_NY:  r_ny <= mres;
            DST_NZ:  r_nz <= mres;
            DST_OX:  r_ox <= mres;
            DST_OY:  r_oy <= mres;
            DST_OZ:  r_oz <= mres;
            default: ;
        endcase
        unique case (i_ctrl.uw.alu_dst)
            DST_T0:  r_t0 <= ares;
            DST_T1:  r_t1 <= ares;
            DST_T2:  r_t2 <= ares;
            DST_NX:  r_nx <= ares;
            DST_NY:  r_ny <= ares;
            DST_NZ:  r_nz <= ares;
            DST_OX:  r_ox <= ares;
            DST_OY:  r_oy <= ares;
            DST_OZ:  r_oz <= ares;
            default: ;
        endcase
        unique case (i_ctrl.uw.col)
            COL_X:   r_col_r <= col_out;
            COL_Y:   r_col_g <= col_out;
            COL_Z:   r_col_b <= col_out;
            default: ;
        endcase
        if (i_ctrl.commit) begin
            r_out_x    <= r_ox;
            r_out_y    <= r_oy;
            r_out_z    <= r_oz;
            r_out_r    <= r_col_r;
            r_out_g    <= r_col_g;
            r_out_b    <= r_col_b;
            r_out_last <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x         <= INIT_X;
            r_y         <= '0;
            r_z         <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            priority if (i_ctrl.init) begin
                r_x   <= INIT_X;
                r_y   <= '0;
                r_z   <= '0;
                r_cnt <= '0;
            end else if (i_ctrl.commit) begin
                r_x   <= last ? INIT_X : r_nx;
                r_y   <= last ? '0 : r_ny;
                r_z   <= last ? '0 : r_nz;
                r_cnt <= last ? '0 : cnt_inc;
            end
            priority if (i_ctrl.commit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_out.valid       = r_out_valid;
        o_out.point_x     = r_out_x;
        o_out.point_y     = r_out_y;
        o_out.point_z     = r_out_z;
        o_out.color_red   = r_out_r;
        o_out.color_green = r_out_g;
        o_out.color_blue  = r_out_b;
        o_out.last_point  = r_out_last;
    end

endmodule

`default_nettype wire

[rtl/lorenz_euler_point_generator.sv]
// A request is accepted only while idle; with restart set, an init step runs before
// the Euler step. No new request is taken until the point commits; the chain of
// dependent products through the single shared multiplier sets the step length.
// The result register frees the sequencer while a point waits downstream.
// Reset (synchronous, active low): configuration registers to defaults, state to (0.1, 0, 0).
`default_nettype none

module lorenz_euler_point_generator import lep_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    lep_in_if.sink                i_in,
    lep_out_if.source             o_out
);

    t_cfg  r_cfg;
    t_ctrl ctrl;
    logic  can_commit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coef_a      <= CFG_A_RST;
            r_cfg.coef_b      <= CFG_B_RST;
            r_cfg.coef_c      <= CFG_C_RST;
            r_cfg.time_step   <= CFG_DT_RST;
            r_cfg.out_scale   <= CFG_SC_RST;
            r_cfg.point_count <= CFG_N_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_COEF_A:      r_cfg.coef_a      <= i_cfg_data[COEF_W-1:0];
                CFG_COEF_B:      r_cfg.coef_b      <= i_cfg_data[COEF_W-1:0];
                CFG_COEF_C:      r_cfg.coef_c      <= i_cfg_data[COEF_W-1:0];
                CFG_TIME_STEP:   r_cfg.time_step   <= i_cfg_data[DT_W-1:0];
                CFG_OUT_SCALE:   r_cfg.out_scale   <= i_cfg_data[SCALE_W-1:0];
                CFG_POINT_COUNT: r_cfg.point_count <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    lep_sequencer u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_can_commit (can_commit),
        .o_ctrl       (ctrl)
    );

    lep_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_ctrl       (ctrl),
        .o_can_commit (can_commit),
        .o_out        (o_out)
    );

endmodule

`default_nettype wire
